[sv/mips1_integer_execute_unit_defines.svh]
// Assertion macros for the integer execute unit.
`ifndef MIPS1_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define MIPS1_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MIEU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MIEU_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIEU_ASSERT(label, clk, rst_n, prop, msg)
`define MIEU_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[sv/mieu_pkg.sv]
// Shared types, opcodes and constants of the integer execute unit.
package mieu_pkg;

  localparam logic [31:0] RegionMask = 32'hf000_0000;
  localparam logic [4:0]  LinkReg    = 5'd31;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpRegimm  = 6'h01;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpBgtz    = 6'h07;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpSlti    = 6'h0a;
  localparam logic [5:0] OpSltiu   = 6'h0b;
  localparam logic [5:0] OpAndi    = 6'h0c;
  localparam logic [5:0] OpOri     = 6'h0d;
  localparam logic [5:0] OpXori    = 6'h0e;
  localparam logic [5:0] OpLui     = 6'h0f;

  localparam logic [5:0] FnSll   = 6'h00;
  localparam logic [5:0] FnSrl   = 6'h02;
  localparam logic [5:0] FnSra   = 6'h03;
  localparam logic [5:0] FnSllv  = 6'h04;
  localparam logic [5:0] FnSrlv  = 6'h06;
  localparam logic [5:0] FnSrav  = 6'h07;
  localparam logic [5:0] FnJr    = 6'h08;
  localparam logic [5:0] FnJalr  = 6'h09;
  localparam logic [5:0] FnMfhi  = 6'h10;
  localparam logic [5:0] FnMthi  = 6'h11;
  localparam logic [5:0] FnMflo  = 6'h12;
  localparam logic [5:0] FnMtlo  = 6'h13;
  localparam logic [5:0] FnMult  = 6'h18;
  localparam logic [5:0] FnMultu = 6'h19;
  localparam logic [5:0] FnDiv   = 6'h1a;
  localparam logic [5:0] FnDivu  = 6'h1b;
  localparam logic [5:0] FnAdd   = 6'h20;
  localparam logic [5:0] FnAddu  = 6'h21;
  localparam logic [5:0] FnSub   = 6'h22;
  localparam logic [5:0] FnSubu  = 6'h23;
  localparam logic [5:0] FnAnd   = 6'h24;
  localparam logic [5:0] FnOr    = 6'h25;
  localparam logic [5:0] FnXor   = 6'h26;
  localparam logic [5:0] FnNor   = 6'h27;
  localparam logic [5:0] FnSlt   = 6'h2a;
  localparam logic [5:0] FnSltu  = 6'h2b;

  // Controller states, one-hot.
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StExec  = 7'b0000100,
    StMul   = 7'b0001000,
    StDiv   = 7'b0010000,
    StDivFx = 7'b0100000,
    StOut   = 7'b1000000
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture instruction and pc
    logic read;      // register file read
    logic exec;      // execute, commit writes
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic div_fix;   // signs, commit HI/LO
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic mul_done;
    logic div_done;
  } dp_status_t;

endpackage

[sv/mieu_datapath.sv]
// Datapath: register file, ALU, branch unit, serial multiplier and divider.
module mieu_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mieu_pkg::dp_cmd_t    cmd_i,
  output mieu_pkg::dp_status_t status_o,
  input  logic [31:0]          instruction_i,
  input  logic [31:0]          inst_address_i,
  output logic                 jump_valid_o,
  output logic [31:0]          jump_target_o,
  output logic                 write_valid_o,
  output logic [4:0]           write_index_o,
  output logic [31:0]          write_value_o,
  output logic                 unsupported_o
);
  import mieu_pkg::*;

  logic [31:0] ir_q, pc_q;
  logic [31:0] gpr_mem [32];
  logic [31:0] ra_q, rb_q;
  logic [31:0] gpr_valid_q;
  logic [31:0] hi_q, lo_q;

  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, a, b, taken, fall;

  assign opc  = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign sh   = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign imm  = {16'h0, ir_q[15:0]};
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign a    = ra_q;
  assign b    = rb_q;
  assign fall  = pc_q + 32'd8;
  assign taken = pc_q + {simm[29:0], 2'b00} + 32'd4;

  // Instruction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ir_q <= instruction_i;
      pc_q <= inst_address_i;
    end
  end

  // Decode and execute
  logic        jv, wv, uns, hi_we, lo_we;
  logic [4:0]  widx;
  logic [31:0] jt, wval, hi_nv, lo_nv;
  logic        rg_ok, cond;

  always_comb begin
    jv = 1'b0; jt = '0; wv = 1'b0; widx = '0; wval = '0; uns = 1'b0;
    hi_we = 1'b0; lo_we = 1'b0; hi_nv = a; lo_nv = a;
    rg_ok = 1'b0; cond = 1'b0;
    case (opc)
      OpSpecial: begin
        widx = rd;
        case (fn)
          FnSll:  begin wv = 1'b1; wval = b << sh; end
          FnSrl:  begin wv = 1'b1; wval = b >> sh; end
          FnSra:  begin wv = 1'b1; wval = 32'($signed(b) >>> sh); end
          FnSllv: begin wv = 1'b1; wval = b << a[4:0]; end
          FnSrlv: begin wv = 1'b1; wval = b >> a[4:0]; end
          FnSrav: begin wv = 1'b1; wval = 32'($signed(b) >>> a[4:0]); end
          FnJr:   begin jv = 1'b1; jt = a; end
          FnJalr: begin jv = 1'b1; jt = a; wv = 1'b1; wval = fall; end
          FnMfhi: begin wv = 1'b1; wval = hi_q; end
          FnMthi: hi_we = 1'b1;
          FnMflo: begin wv = 1'b1; wval = lo_q; end
          FnMtlo: lo_we = 1'b1;
          FnMult, FnMultu, FnDiv, FnDivu: ;
          FnAdd, FnAddu: begin wv = 1'b1; wval = a + b; end
          FnSub, FnSubu: begin wv = 1'b1; wval = a - b; end
          FnAnd:  begin wv = 1'b1; wval = a & b; end
          FnOr:   begin wv = 1'b1; wval = a | b; end
          FnXor:  begin wv = 1'b1; wval = a ^ b; end
          FnNor:  begin wv = 1'b1; wval = ~(a | b); end
          FnSlt:  begin wv = 1'b1; wval = {31'h0, $signed(a) < $signed(b)}; end
          FnSltu: begin wv = 1'b1; wval = {31'h0, a < b}; end
          default: uns = 1'b1;
        endcase
      end
      OpRegimm: begin
        rg_ok = (rt[3:1] == 3'b000);
        if (!rg_ok) begin
          uns = 1'b1;
        end else begin
          cond = rt[0] ? !a[31] : a[31];
          jv = 1'b1;
          jt = cond ? taken : fall;
          wv = rt[4]; widx = LinkReg; wval = fall;
        end
      end
      OpJ, OpJal: begin
        jv = 1'b1;
        jt = ((pc_q + 32'd4) & RegionMask) | {4'h0, ir_q[25:0], 2'b00};
        wv = (opc == OpJal); widx = LinkReg; wval = fall;
      end
      OpBeq, OpBne, OpBlez, OpBgtz: begin
        case (opc)
          OpBeq:   cond = (a == b);
          OpBne:   cond = (a != b);
          OpBlez:  cond = a[31] || (a == '0);
          default: cond = !a[31] && (a != '0);
        endcase
        jv = 1'b1;
        jt = cond ? taken : fall;
      end
      OpAddi, OpAddiu: begin wv = 1'b1; widx = rt; wval = a + simm; end
      OpSlti:  begin wv = 1'b1; widx = rt; wval = {31'h0, $signed(a) < $signed(simm)}; end
      OpSltiu: begin wv = 1'b1; widx = rt; wval = {31'h0, a < simm}; end
      OpAndi:  begin wv = 1'b1; widx = rt; wval = a & imm; end
      OpOri:   begin wv = 1'b1; widx = rt; wval = a | imm; end
      OpXori:  begin wv = 1'b1; widx = rt; wval = a ^ imm; end
      OpLui:   begin wv = 1'b1; widx = rt; wval = {ir_q[15:0], 16'h0}; end
      default: uns = 1'b1;
    endcase
    if (widx == '0) wv = 1'b0;
    if (!wv) begin
      widx = '0; wval = '0;
    end
  end

  assign status_o.is_mul = (opc == OpSpecial) && (fn == FnMult || fn == FnMultu);
  assign status_o.is_div = (opc == OpSpecial) && (fn == FnDiv || fn == FnDivu);

  // Register file: memory plus per-entry valid bits for the reset value
  logic [31:0] rd_a_q, rd_b_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wv) gpr_mem[widx] <= wval;
    if (cmd_i.read) begin
      rd_a_q <= gpr_mem[rs];
      rd_b_q <= gpr_mem[rt];
    end
  end

  logic va_q, vb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_valid_q <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (cmd_i.exec && wv) gpr_valid_q[widx] <= 1'b1;
      if (cmd_i.read) begin
        va_q <= gpr_valid_q[rs] && (rs != '0);
        vb_q <= gpr_valid_q[rt] && (rt != '0);
      end
    end
  end
  assign ra_q = va_q ? rd_a_q : '0;
  assign rb_q = vb_q ? rd_b_q : '0;

  // Shift-add multiplier on magnitudes, one bit a cycle
  logic [31:0] m_acc_q, m_mpr_q, m_mcd_q;
  logic [5:0]  m_cnt_q;
  logic        m_neg_q;
  logic [32:0] m_sum;
  logic [63:0] m_prod, m_res;
  logic        sgn_op;
  logic [31:0] mag_a, mag_b;
  assign sgn_op = !fn[0];
  assign mag_a  = (sgn_op && a[31]) ? -a : a;
  assign mag_b  = (sgn_op && b[31]) ? -b : b;
  assign m_sum  = m_mpr_q[0] ? ({1'b0, m_acc_q} + {1'b0, m_mcd_q}) : {1'b0, m_acc_q};
  assign m_prod = {m_acc_q, m_mpr_q};
  assign m_res  = m_neg_q ? -m_prod : m_prod;

  // Restoring divider, one quotient bit a cycle
  logic [31:0] d_rem_q, d_quo_q, d_dvs_q;
  logic [5:0]  d_cnt_q;
  logic        d_qneg_q, d_rneg_q, d_zero_q;
  logic [32:0] d_trial;
  assign d_trial = {d_rem_q, d_quo_q[31]} - {1'b0, d_dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_cnt_q <= '0;
      d_cnt_q <= '0;
    end else begin
      if (cmd_i.mul_start) m_cnt_q <= '0;
      else if (cmd_i.mul_step) m_cnt_q <= m_cnt_q + 6'd1;
      if (cmd_i.div_start) d_cnt_q <= '0;
      else if (cmd_i.div_step) d_cnt_q <= d_cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      m_acc_q <= '0;
      m_mpr_q <= mag_b;
      m_mcd_q <= mag_a;
      m_neg_q <= sgn_op && (a[31] ^ b[31]);
    end else if (cmd_i.mul_step) begin
      {m_acc_q, m_mpr_q} <= {m_sum, m_mpr_q[31:1]};
    end
    if (cmd_i.div_start) begin
      d_rem_q  <= '0;
      d_quo_q  <= mag_a;
      d_dvs_q  <= mag_b;
      d_qneg_q <= sgn_op && (a[31] ^ b[31]);
      d_rneg_q <= sgn_op && a[31];
      d_zero_q <= (b == '0);
    end else if (cmd_i.div_step) begin
      if (!d_trial[32]) begin
        d_rem_q <= d_trial[31:0];
        d_quo_q <= {d_quo_q[30:0], 1'b1};
      end else begin
        d_rem_q <= {d_rem_q[30:0], d_quo_q[31]};
        d_quo_q <= {d_quo_q[30:0], 1'b0};
      end
    end
  end

  assign status_o.mul_done = (m_cnt_q == 6'd31) && cmd_i.mul_step;
  assign status_o.div_done = (d_cnt_q == 6'd31) && cmd_i.div_step;

  // HI/LO
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (cmd_i.exec) begin
      if (hi_we) hi_q <= hi_nv;
      if (lo_we) lo_q <= lo_nv;
    end else if (cmd_i.mul_step && (m_cnt_q == 6'd32)) begin
      hi_q <= m_res[63:32];
      lo_q <= m_res[31:0];
    end else if (cmd_i.div_fix && !d_zero_q) begin
      lo_q <= d_qneg_q ? -d_quo_q : d_quo_q;
      hi_q <= d_rneg_q ? -d_rem_q : d_rem_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      jump_valid_o  <= jv;
      jump_target_o <= jt;
      write_valid_o <= wv;
      write_index_o <= widx;
      write_value_o <= wval;
      unsupported_o <= uns;
    end
  end

endmodule

[sv/mieu_ctrl.sv]
// Controller: sequences read, execute, multiply and divide per instruction.
module mieu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mieu_pkg::dp_cmd_t    cmd_o,
  input  mieu_pkg::dp_status_t status_i
);
  import mieu_pkg::*;
  `include "mips1_integer_execute_unit_defines.svh"

  ctrl_state_e state_q, state_d;
  logic mul_last_q, mul_last_d;

  always_comb begin
    state_d    = state_q;
    mul_last_d = mul_last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d = StExec;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (status_i.is_mul) begin
          cmd_o.mul_start = 1'b1;
          mul_last_d = 1'b0;
          state_d = StMul;
        end else if (status_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StOut;
        end
      end
      StMul: begin
        // 32 add-shift steps, then one commit step
        cmd_o.mul_step = 1'b1;
        if (mul_last_q) state_d = StOut;
        if (status_i.mul_done) mul_last_d = 1'b1;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = StDivFx;
      end
      StDivFx: begin
        cmd_o.div_fix = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mul_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mul_last_q <= mul_last_d;
    end
  end

  `MIEU_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `MIEU_ASSERT(a_no_both, clk_i, rst_ni, !(in_ready_o && out_valid_o), "accept while result held")
  `MIEU_ASSERT(a_load_read, clk_i, rst_ni, cmd_o.load |=> cmd_o.read, "load not followed by read")
  `MIEU_ASSERT(a_fix_out, clk_i, rst_ni, cmd_o.div_fix |=> out_valid_o, "divide commit not followed by result")

endmodule

[sv/mips1_integer_execute_unit.sv]
// Top level of the MIPS I integer execute unit.
// Instructions pass through the read and execute states before the result is offered;
// MULT/MULTU add a serial shift-add multiply, DIV/DIVU a restoring divide and sign fix-up.
// The unit handles one instruction at a time; the controller takes the next transfer
// the cycle after the result transfer.
// Reset clears all GPRs (valid bits), HI, LO and the controller at once.
module mips1_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] inst_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        jump_valid_o,
  output logic [31:0] jump_target_o,
  output logic        write_valid_o,
  output logic [4:0]  write_index_o,
  output logic [31:0] write_value_o,
  output logic        unsupported_o
);
  import mieu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mieu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .status_i(status)
  );

  mieu_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .instruction_i, .inst_address_i,
    .jump_valid_o, .jump_target_o, .write_valid_o, .write_index_o,
    .write_value_o, .unsupported_o
  );

endmodule
